@@ rtl/mhg_pkg.sv @@
// Shared types, codes and lookup tables for the MP3 header and gain decoder.
package mhg_pkg;

  // Header field codes
  localparam logic [7:0] SyncByte   = 8'hFF;
  localparam logic [2:0] SyncTop    = 3'b111;
  localparam logic [1:0] Ver25      = 2'b00;
  localparam logic [1:0] VerRsvd    = 2'b01;
  localparam logic [1:0] Ver2       = 2'b10;
  localparam logic [1:0] Ver1       = 2'b11;
  localparam logic [1:0] LayerThree = 2'b01;
  localparam logic [3:0] BrFree     = 4'd0;
  localparam logic [3:0] BrBad      = 4'd15;
  localparam logic [1:0] RateRsvd   = 2'b11;
  localparam logic [1:0] ModeMono   = 2'b11;

  // Frame geometry
  localparam logic [10:0] SpfMpeg1 = 11'd1152;
  localparam logic [10:0] SpfLow   = 11'd576;
  // (samples / 8) * 1000, folds the kbps scaling into one constant
  localparam logic [17:0] NumMpeg1 = 18'd144000;
  localparam logic [17:0] NumLow   = 18'd72000;

  // Side info start and granule length offsets, in bits
  localparam logic [6:0] SideStart    = 7'd32;
  localparam logic [6:0] SideStartCrc = 7'd48;
  localparam logic [6:0] OffM1Mono    = 7'd18;
  localparam logic [6:0] OffM1Stereo  = 7'd20;
  localparam logic [6:0] OffLowMono   = 7'd9;
  localparam logic [6:0] OffLowStereo = 7'd10;
  localparam logic [6:0] GainSkip     = 7'd21;
  localparam logic [6:0] FrameTopBit  = 7'd103;

  // Divider geometry: quotient bits and bits resolved per cycle
  localparam int QuotBits = 12;
  localparam int BitsPerCycle = 3;
  // Remainder width: sample rate shifted up to the top quotient bit
  localparam int DivW = 16 + QuotBits - 1;
  // Count of the last divide cycle
  localparam logic [1:0] DivLastStep = 2'(QuotBits / BitsPerCycle - 1);

  typedef struct packed {
    logic [31:0] header_word;
    logic [63:0] side_bytes_low;
    logic [7:0]  side_byte_last;
  } mhg_in_t;

  typedef struct packed {
    logic        header_valid;
    logic [10:0] frame_length;
    logic [15:0] sample_rate;
    logic [10:0] samples_per_frame;
    logic        low_rate_ext;
    logic        mono_mode;
    logic        crc_present;
    logic [7:0]  gr0_gain;
  } mhg_out_t;

  // Classified header waiting for the length division
  typedef struct packed {
    mhg_out_t    info;
    logic [25:0] numer;
    logic        pad;
  } mhg_job_t;

  // MPEG1 bitrate in kbps
  function automatic logic [8:0] br_mpeg1(input logic [3:0] idx);
    logic [8:0] v;
    case (idx)
      4'd1:    v = 9'd32;
      4'd2:    v = 9'd40;
      4'd3:    v = 9'd48;
      4'd4:    v = 9'd56;
      4'd5:    v = 9'd64;
      4'd6:    v = 9'd80;
      4'd7:    v = 9'd96;
      4'd8:    v = 9'd112;
      4'd9:    v = 9'd128;
      4'd10:   v = 9'd160;
      4'd11:   v = 9'd192;
      4'd12:   v = 9'd224;
      4'd13:   v = 9'd256;
      4'd14:   v = 9'd320;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // MPEG2 and MPEG2.5 bitrate in kbps
  function automatic logic [8:0] br_low(input logic [3:0] idx);
    logic [8:0] v;
    case (idx)
      4'd1:    v = 9'd8;
      4'd2:    v = 9'd16;
      4'd3:    v = 9'd24;
      4'd4:    v = 9'd32;
      4'd5:    v = 9'd40;
      4'd6:    v = 9'd48;
      4'd7:    v = 9'd56;
      4'd8:    v = 9'd64;
      4'd9:    v = 9'd80;
      4'd10:   v = 9'd96;
      4'd11:   v = 9'd112;
      4'd12:   v = 9'd128;
      4'd13:   v = 9'd144;
      4'd14:   v = 9'd160;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // MPEG1 sampling rate in Hz
  function automatic logic [15:0] base_rate(input logic [1:0] idx);
    logic [15:0] v;
    case (idx)
      2'd0:    v = 16'd44100;
      2'd1:    v = 16'd48000;
      2'd2:    v = 16'd32000;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/mp3_header_gain_decoder.sv @@
// MP3 Layer III frame header and first-granule gain decoder, top level.
// Result path from input accept: queue write, frame length divider steps, output register.
// Throughput: set by the frame length divider, resolving 3 quotient bits per cycle over
// 12 bits and taking the next header as it delivers the last; the input takes a word every
// cycle until the 2-entry queue fills.
// Reset: asynchronous, active low; clears queue occupancy, divider and output valid flags.
module mp3_header_gain_decoder import mhg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mhg_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mhg_out_t out_data_o
);

  mhg_job_t front_job;
  logic     q_valid;
  logic     q_ready;
  mhg_job_t q_job;

  // Classify the header
  mhg_front u_front (
    .hdr_i (in_data_i),
    .job_o (front_job)
  );

  // Decouple classifier from divider
  mhg_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (in_valid_i),
    .wr_ready_o (in_ready_o),
    .wr_data_i  (front_job),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_job)
  );

  // Divide out the frame length and deliver
  mhg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/mhg_front.sv @@
// Header classifier: checks sync and indexes, picks rates and extracts the gain.
module mhg_front import mhg_pkg::*; (
  input  mhg_in_t  hdr_i,
  output mhg_job_t job_o
);

  logic [103:0] frame;
  logic [31:0]  hw;
  logic [1:0]   ver;
  logic [1:0]   layer;
  logic [3:0]   br_idx;
  logic [1:0]   sr_idx;
  logic         ok;
  logic         lsf;
  logic         mono;
  logic         crc;
  logic [8:0]   kbps;
  logic [15:0]  rate;
  logic [25:0]  mul_a;
  logic [25:0]  mul_b;
  logic [6:0]   off;
  logic [6:0]   len_hi;
  logic [6:0]   gain_hi;
  logic [11:0]  p23_len;
  logic [7:0]   gain;

  assign frame  = {hdr_i.header_word, hdr_i.side_bytes_low, hdr_i.side_byte_last};
  assign hw     = hdr_i.header_word;
  assign ver    = hw[20:19];
  assign layer  = hw[18:17];
  assign br_idx = hw[15:12];
  assign sr_idx = hw[11:10];
  assign lsf    = (ver != Ver1);
  assign mono   = (hw[7:6] == ModeMono);
  assign crc    = ~hw[16];

  // Validate sync and every index
  assign ok = (hw[31:24] == SyncByte) && (hw[23:21] == SyncTop) &&
              (ver != VerRsvd) && (layer == LayerThree) &&
              (br_idx != BrFree) && (br_idx != BrBad) && (sr_idx != RateRsvd);

  // Scale rate by version: halve for MPEG2, quarter for MPEG2.5
  always_comb begin
    case (ver)
      Ver2:    rate = base_rate(sr_idx) >> 1;
      Ver25:   rate = base_rate(sr_idx) >> 2;
      default: rate = base_rate(sr_idx);
    endcase
  end

  // Form the dividend (samples / 8) * bitrate in bits per second
  assign kbps  = lsf ? br_low(br_idx) : br_mpeg1(br_idx);
  assign mul_a = {17'd0, kbps};
  assign mul_b = {8'd0, (lsf ? NumLow : NumMpeg1)};

  // Locate the granule length and gain fields in the side info
  always_comb begin
    case ({lsf, mono})
      2'b00:   off = OffM1Stereo;
      2'b01:   off = OffM1Mono;
      2'b10:   off = OffLowStereo;
      default: off = OffLowMono;
    endcase
  end

  assign len_hi  = FrameTopBit - (crc ? SideStartCrc : SideStart) - off;
  assign gain_hi = len_hi - GainSkip;
  assign p23_len = frame[len_hi -: 12];
  assign gain    = (p23_len == 12'd0) ? 8'd0 : frame[gain_hi -: 8];

  // Pack the job; an invalid header carries all zeros
  always_comb begin
    job_o = '0;
    if (ok) begin
      job_o.info.header_valid      = 1'b1;
      job_o.info.sample_rate       = rate;
      job_o.info.samples_per_frame = lsf ? SpfLow : SpfMpeg1;
      job_o.info.low_rate_ext      = lsf;
      job_o.info.mono_mode         = mono;
      job_o.info.crc_present       = crc;
      job_o.info.gr0_gain          = gain;
      job_o.numer                  = mul_a * mul_b;
      job_o.pad                    = hw[9];
    end
  end

endmodule

@@ rtl/mhg_fifo.sv @@
// Two-entry queue between the header classifier and the length divider.
module mhg_fifo import mhg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_valid_i,
  output logic     wr_ready_o,
  input  mhg_job_t wr_data_i,
  output logic     rd_valid_o,
  input  logic     rd_ready_i,
  output mhg_job_t rd_data_o
);

  mhg_job_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ rtl/mhg_back.sv @@
// Frame length divider, three quotient bits a cycle, with the output register.
module mhg_back import mhg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  output logic     job_ready_o,
  input  mhg_job_t job_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mhg_out_t out_data_o
);

  logic                busy_q;
  logic                fin_q;
  logic [1:0]          cnt_q;
  logic [DivW-1:0]     r_q, r_c;
  logic [DivW-1:0]     d_q, d_c;
  logic [QuotBits-1:0] q_q, q_c;
  logic [QuotBits-1:0] q_res;
  mhg_out_t            info_q;
  logic                pad_q;
  logic                out_valid_q;
  mhg_out_t            out_q, out_d;
  logic                avail;
  logic                deliver;
  logic                job_acc;
  logic                step;
  logic [10:0]         len;

  // Resolve three quotient bits by restoring subtraction
  always_comb begin
    r_c = r_q;
    d_c = d_q;
    q_c = q_q;
    for (int j = 0; j < BitsPerCycle; j++) begin
      if (r_c >= d_c) begin
        r_c = r_c - d_c;
        q_c = {q_c[QuotBits-2:0], 1'b1};
      end else begin
        q_c = {q_c[QuotBits-2:0], 1'b0};
      end
      d_c = d_c >> 1;
    end
  end

  assign step        = busy_q && !fin_q;
  assign avail       = busy_q && (fin_q || (cnt_q == DivLastStep));
  assign deliver     = avail && (!out_valid_q || out_ready_i);
  assign job_ready_o = !busy_q || deliver;
  assign job_acc     = job_valid_i && job_ready_o;
  assign q_res       = fin_q ? q_q : q_c;
  assign len         = info_q.header_valid ? (q_res[10:0] + {10'd0, pad_q}) : 11'd0;

  // Merge the frame length into the finished word
  always_comb begin
    out_d              = info_q;
    out_d.frame_length = len;
  end

  // Sequence the divider and the output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      fin_q       <= 1'b0;
      cnt_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_acc) begin
        busy_q <= 1'b1;
        fin_q  <= 1'b0;
        cnt_q  <= 2'd0;
      end else if (deliver) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b0;
      end else if (step) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == DivLastStep) begin
          fin_q <= 1'b1;
        end
      end
      if (deliver) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load operands, iterate, and capture the finished word
  always_ff @(posedge clk_i) begin
    if (job_acc) begin
      r_q    <= DivW'(job_i.numer);
      d_q    <= {job_i.info.sample_rate, {(QuotBits-1){1'b0}}};
      q_q    <= '0;
      info_q <= job_i.info;
      pad_q  <= job_i.pad;
    end else if (step) begin
      r_q <= r_c;
      d_q <= d_c;
      q_q <= q_c;
    end
    if (deliver) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
